/* rtl/core/lsrf_pkg.sv */
// ----------------------------------------------------------------------------
// lsrf_pkg
// Shared types, size codes and helpers for the logical shift unit.
// ----------------------------------------------------------------------------
package lsrf_pkg;

   // operand size codes (code three is handled as long)
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;
   localparam logic [1:0] SIZE_LONG = 2'd2;

   // opcode field positions
   localparam int OPC_REG_LSB = 0;
   localparam int OPC_CNT_SRC = 5;
   localparam int OPC_DIR     = 8;
   localparam int OPC_CNT_LSB = 9;

   // cycle count bases
   localparam logic [7:0] BASE_SHORT = 8'd6;
   localparam logic [7:0] BASE_LONG  = 8'd8;

   // immediate count of zero stands for eight
   localparam logic [5:0] IMM_ZERO_COUNT = 6'd8;

   // decoded instruction, first stage output
   typedef struct packed {
      logic [31:0] dest_value;
      logic [31:0] sized_value;
      logic [1:0]  size_code;
      logic [5:0]  count;
      logic        left;
      logic        over;
      logic        x_flag_in;
      logic [2:0]  dest_reg;
      logic [7:0]  cycles;
   } dec_type;

   // shifted value and carry, second stage output
   typedef struct packed {
      logic [31:0] dest_value;
      logic [31:0] shifted;
      logic [1:0]  size_code;
      logic        flag_c;
      logic        flag_x;
      logic [2:0]  dest_reg;
      logic [7:0]  cycles;
   } shf_type;

   // final result item
   typedef struct packed {
      logic [31:0] result_value;
      logic [2:0]  dest_reg;
      logic        flag_n;
      logic        flag_z;
      logic        flag_v;
      logic        flag_c;
      logic        flag_x;
      logic [7:0]  cycles;
   } rsp_type;

   // mask of the operand bits for a size code
   function automatic logic [31:0] size_mask(input logic [1:0] size_code);
      logic [31:0] mask;
      unique case (size_code)
         SIZE_BYTE: mask = 32'h0000_00FF;
         SIZE_WORD: mask = 32'h0000_FFFF;
         default:   mask = 32'hFFFF_FFFF;
      endcase
      return mask;
   endfunction

   // operand width in bits for a size code
   function automatic logic [5:0] size_width(input logic [1:0] size_code);
      logic [5:0] width;
      unique case (size_code)
         SIZE_BYTE: width = 6'd8;
         SIZE_WORD: width = 6'd16;
         default:   width = 6'd32;
      endcase
      return width;
   endfunction

endpackage

/* rtl/core/lsrf_if.sv */
// ----------------------------------------------------------------------------
// lsrf_if
// Request and response channels of the logical shift unit.
// ----------------------------------------------------------------------------
interface lsrf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] opcode;
   logic [1:0]  size_code;
   logic [31:0] dest_value;
   logic [31:0] count_value;
   logic        x_flag_in;

   modport source (output valid, opcode, size_code, dest_value, count_value, x_flag_in,
                   input ready);
   modport sink   (input valid, opcode, size_code, dest_value, count_value, x_flag_in,
                   output ready);
endinterface

interface lsrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic [2:0]  dest_reg;
   logic        flag_n;
   logic        flag_z;
   logic        flag_v;
   logic        flag_c;
   logic        flag_x;
   logic [7:0]  cycles;

   modport source (output valid, result_value, dest_reg, flag_n, flag_z, flag_v, flag_c,
                          flag_x, cycles,
                   input ready);
   modport sink   (input valid, result_value, dest_reg, flag_n, flag_z, flag_v, flag_c,
                         flag_x, cycles,
                   output ready);
endinterface

/* rtl/core/lsrf_decode.sv */
// ----------------------------------------------------------------------------
// lsrf_decode
// First stage: count selection, operand sizing and cycle count.
// ----------------------------------------------------------------------------
module lsrf_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [15:0]        opcode,
   input  logic [1:0]         size_code,
   input  logic [31:0]        dest_value,
   input  logic [31:0]        count_value,
   input  logic               x_flag_in,
   output logic               out_valid,
   input  logic               out_ready,
   output lsrf_pkg::dec_type  out_data
);
   import lsrf_pkg::*;

   logic       valid_ff;
   dec_type    data_ff;
   dec_type    data_in;
   logic [2:0] imm_count;
   logic [5:0] count;
   logic [7:0] base;

   // shift count from immediate field or register
   always_comb begin
      imm_count = opcode[OPC_CNT_LSB +: 3];
      if (opcode[OPC_CNT_SRC]) begin
         count = count_value[5:0];
      end else if (imm_count == 3'd0) begin
         count = IMM_ZERO_COUNT;
      end else begin
         count = {3'd0, imm_count};
      end
   end

   // decoded fields
   always_comb begin
      base                = (size_code == SIZE_BYTE || size_code == SIZE_WORD) ?
                            BASE_SHORT : BASE_LONG;
      data_in.dest_value  = dest_value;
      data_in.sized_value = dest_value & size_mask(size_code);
      data_in.size_code   = size_code;
      data_in.count       = count;
      data_in.left        = opcode[OPC_DIR];
      data_in.over        = count > size_width(size_code);
      data_in.x_flag_in   = x_flag_in;
      data_in.dest_reg    = opcode[OPC_REG_LSB +: 3];
      data_in.cycles      = base + {1'b0, count, 1'b0};
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/lsrf_shift.sv */
// ----------------------------------------------------------------------------
// lsrf_shift
// Second stage: barrel shift of the sized operand and carry extraction.
// ----------------------------------------------------------------------------
module lsrf_shift (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  lsrf_pkg::dec_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output lsrf_pkg::shf_type  out_data
);
   import lsrf_pkg::*;

   logic        valid_ff;
   shf_type     data_ff;
   shf_type     data_in;
   logic [63:0] left_wide;
   logic [63:0] right_wide;
   logic        carry_left;
   logic [31:0] shifted;
   logic        carry;

   // both directions over a double width word; the carry falls out next to the operand
   always_comb begin
      left_wide  = {32'd0, in_data.sized_value} << in_data.count;
      right_wide = {in_data.sized_value, 32'd0} >> in_data.count;
      unique case (in_data.size_code)
         SIZE_BYTE: carry_left = left_wide[8];
         SIZE_WORD: carry_left = left_wide[16];
         default:   carry_left = left_wide[32];
      endcase
   end

   // counts beyond the width clear everything
   always_comb begin
      if (in_data.over) begin
         shifted = 32'd0;
         carry   = 1'b0;
      end else if (in_data.left) begin
         shifted = left_wide[31:0];
         carry   = carry_left;
      end else begin
         shifted = right_wide[63:32];
         carry   = right_wide[31];
      end
   end

   // stage payload; a zero count keeps x
   always_comb begin
      data_in.dest_value = in_data.dest_value;
      data_in.shifted    = shifted;
      data_in.size_code  = in_data.size_code;
      data_in.flag_c     = carry;
      data_in.flag_x     = (in_data.count == 6'd0) ? in_data.x_flag_in : carry;
      data_in.dest_reg   = in_data.dest_reg;
      data_in.cycles     = in_data.cycles;
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/lsrf_flags.sv */
// ----------------------------------------------------------------------------
// lsrf_flags
// Third stage: merge into the register, N and Z flags, output register.
// ----------------------------------------------------------------------------
module lsrf_flags (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  lsrf_pkg::shf_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output lsrf_pkg::rsp_type  out_data
);
   import lsrf_pkg::*;

   logic        valid_ff;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [31:0] mask;
   logic [31:0] sized_res;
   logic        sign;

   // sized result and its sign bit
   always_comb begin
      mask      = size_mask(in_data.size_code);
      sized_res = in_data.shifted & mask;
      unique case (in_data.size_code)
         SIZE_BYTE: sign = sized_res[7];
         SIZE_WORD: sign = sized_res[15];
         default:   sign = sized_res[31];
      endcase
   end

   // result item
   always_comb begin
      data_in.result_value = (in_data.dest_value & ~mask) | sized_res;
      data_in.dest_reg     = in_data.dest_reg;
      data_in.flag_n       = sign;
      data_in.flag_z       = (sized_res == 32'd0);
      data_in.flag_v       = 1'b0;
      data_in.flag_c       = in_data.flag_c;
      data_in.flag_x       = in_data.flag_x;
      data_in.cycles       = in_data.cycles;
   end

   // output register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/logical_shift_register_flags.sv */
// a request is registered in each stage in turn before the response is valid
// throughput: one request per cycle while the response is not stalled, set by the three register stages
// (decode, barrel shift, flags and output register)
// a stalled response holds every stage that holds a request; nothing is dropped or repeated
// reset: synchronous, clears the stage valid bits only
// ----------------------------------------------------------------------------
// logical_shift_register_flags
// Register-form logical shift left/right with N, Z, V, C, X flags and the
// instruction cycle count, as a three-stage pipeline.
// ----------------------------------------------------------------------------
module logical_shift_register_flags (
   input  logic       clock,
   input  logic       reset,
   lsrf_req_if.sink   req_chan,
   lsrf_rsp_if.source rsp_chan
);
   import lsrf_pkg::*;

   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    shf_valid;
   logic    shf_ready;
   shf_type shf_data;
   rsp_type rsp_data;

   // decode stage
   lsrf_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .opcode      (req_chan.opcode),
      .size_code   (req_chan.size_code),
      .dest_value  (req_chan.dest_value),
      .count_value (req_chan.count_value),
      .x_flag_in   (req_chan.x_flag_in),
      .out_valid   (dec_valid),
      .out_ready   (dec_ready),
      .out_data    (dec_data)
   );

   // shift stage
   lsrf_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (shf_valid),
      .out_ready (shf_ready),
      .out_data  (shf_data)
   );

   // flags stage and output register
   lsrf_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shf_valid),
      .in_ready  (shf_ready),
      .in_data   (shf_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   // response payload
   assign rsp_chan.result_value = rsp_data.result_value;
   assign rsp_chan.dest_reg     = rsp_data.dest_reg;
   assign rsp_chan.flag_n       = rsp_data.flag_n;
   assign rsp_chan.flag_z       = rsp_data.flag_z;
   assign rsp_chan.flag_v       = rsp_data.flag_v;
   assign rsp_chan.flag_c       = rsp_data.flag_c;
   assign rsp_chan.flag_x       = rsp_data.flag_x;
   assign rsp_chan.cycles       = rsp_data.cycles;

   // x differs from c only for a zero count, which costs the base cycles
   a_x_only_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.flag_x != rsp_chan.flag_c) |->
         (rsp_chan.cycles == BASE_SHORT || rsp_chan.cycles == BASE_LONG))
      else $error("x differs from c for a nonzero count");

   // a carry needs at least one bit shifted
   a_carry_needs_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.flag_c |-> (rsp_chan.cycles > BASE_SHORT))
      else $error("carry set with no shift");

   // a stalled shift stage holds its carry for the flags stage
   a_shift_stall_holds: assert property (@(posedge clock) disable iff (reset)
      shf_valid && !shf_ready |=> shf_valid && $stable(shf_data))
      else $error("shift stage changed while stalled");

endmodule
